// ===== src/vaos_pkg.sv =====
// Shared definitions for the voice allocator: field widths, request codes and the
// command and status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package vaos_pkg;

  localparam int NUM_VOICES_DEF = 16;

  localparam int REQ_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int ID_W    = 16;
  localparam int VEL_W   = 7;
  localparam int ENDED_W = 4;
  localparam int INDEX_W = 4;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 5;
  localparam int AGE_W   = 64;

  // One voice table entry in the RAM: {age, ident, note}.
  localparam int ENTRY_W = AGE_W + ID_W + NOTE_W;

  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ENV_END  = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_issue;
    logic write_voice;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_write;
    logic scan_last;
    logic alloc_mode;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/vaos_req_if.sv =====
// Request channel of the voice allocator: valid/ready handshake and event fields.
// Depends on vaos_pkg.
`default_nettype none

interface vaos_req_if import vaos_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [NOTE_W-1:0]  note;
  logic [ID_W-1:0]    voice_id;
  logic [VEL_W-1:0]   velocity;
  logic               bend_update;
  logic [ENDED_W-1:0] ended_voice;

  modport source (
    output valid, req_type, note, voice_id, velocity, bend_update, ended_voice,
    input  ready
  );
  modport sink (
    input  valid, req_type, note, voice_id, velocity, bend_update, ended_voice,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/vaos_res_if.sv =====
// Result channel of the voice allocator: valid/ready handshake and result fields.
// Depends on vaos_pkg.
`default_nettype none

interface vaos_res_if import vaos_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               allocated;
  logic [INDEX_W-1:0] voice_index;
  logic               stolen;
  logic [MASK_W-1:0]  release_mask;
  logic [COUNT_W-1:0] active_count;

  modport source (
    output valid, allocated, voice_index, stolen, release_mask, active_count,
    input  ready
  );
  modport sink (
    input  valid, allocated, voice_index, stolen, release_mask, active_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/vaos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module vaos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/vaos_ctrl.sv =====
// Sequencing state machine of the voice allocator: takes a request, runs the table
// scan, the voice write and the result transfer. Depends on vaos_pkg.
`default_nettype none

module vaos_ctrl import vaos_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (st.need_scan) state_next = S_SCAN;
          else if (st.need_write)    state_next = S_WRITE;
          else                       state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.scan_last) state_next = S_DRAIN;
      end
      // The last entry read comes back in this cycle.
      S_DRAIN: begin
        state_next = st.alloc_mode ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        cmd.write_voice = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/vaos_dp.sv =====
// Datapath of the voice allocator: active and held flags, active count, age counter,
// the voice table RAM with its scan logic, and the result register.
// Depends on vaos_pkg and vaos_ram.
`default_nettype none

module vaos_dp import vaos_pkg::*; #(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [NOTE_W-1:0]  in_note,
  input  logic [ID_W-1:0]    in_voice_id,
  input  logic [VEL_W-1:0]   in_velocity,
  input  logic               in_bend_update,
  input  logic [ENDED_W-1:0] in_ended_voice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_allocated,
  output logic [INDEX_W-1:0] out_voice_index,
  output logic               out_stolen,
  output logic [MASK_W-1:0]  out_release_mask,
  output logic [COUNT_W-1:0] out_active_count
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam logic [VW-1:0] LAST_VOICE = VW'(NUM_VOICES - 1);

  logic [NUM_VOICES-1:0] active, held;
  logic [CW-1:0]         count;
  logic [AGE_W-1:0]      age_counter;

  logic                  mode_alloc;
  logic [NOTE_W-1:0]     item_note;
  logic [ID_W-1:0]       item_id;

  logic [VW-1:0]         addr, rd_idx, pick, free_idx;
  logic                  rd_valid, found;
  logic [AGE_W-1:0]      best_age;
  logic                  r_alloc, r_stolen;
  logic [MASK_W-1:0]     r_mask;

  logic [ENTRY_W-1:0]    rd_data;
  logic [AGE_W-1:0]      rd_age, age_next;
  logic [ID_W-1:0]       rd_id;
  logic [NOTE_W-1:0]     rd_note;

  logic                  is_on, is_off, is_end, all_active;
  logic [VW+ENDED_W-1:0] end_ext;
  logic [VW-1:0]         end_idx;
  logic                  end_clear;
  logic                  rel_hit, age_better, rd_in_mask;
  logic [VW+INDEX_W-1:0] rd_ext, pick_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  assign is_on      = (in_req_type == REQ_NOTE_ON) && (in_velocity != '0);
  assign is_off     = (in_req_type == REQ_NOTE_OFF) && !in_bend_update;
  assign is_end     = (in_req_type == REQ_ENV_END);
  assign all_active = &active;

  // Lowest-numbered inactive voice; voice 0 when every voice is active.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!active[i]) free_idx = VW'(i);
    end
  end

  assign end_ext   = (VW + ENDED_W)'(in_ended_voice);
  assign end_idx   = end_ext[VW-1:0];
  assign end_clear = is_end && (end_ext < (VW + ENDED_W)'(NUM_VOICES))
                     && active[end_idx] && !held[end_idx];

  assign st.need_scan  = is_off || (is_on && all_active);
  assign st.need_write = is_on && !all_active;
  assign st.scan_last  = (addr == LAST_VOICE);
  assign st.alloc_mode = mode_alloc;
  assign st.out_free   = !out_valid || out_ready;

  assign rd_age  = rd_data[ENTRY_W-1 -: AGE_W];
  assign rd_id   = rd_data[NOTE_W +: ID_W];
  assign rd_note = rd_data[NOTE_W-1:0];

  assign rel_hit    = rd_valid && !mode_alloc && active[rd_idx] && held[rd_idx]
                      && ((rd_id == item_id) || (rd_note == item_note));
  assign age_better = rd_valid && mode_alloc && !held[rd_idx]
                      && (!found || (rd_age < best_age));

  // Only the voices that fit in the result mask are reported.
  assign rd_ext     = (VW + INDEX_W)'(rd_idx);
  assign rd_in_mask = rd_ext < (VW + INDEX_W)'(MASK_W);
  assign pick_ext   = (VW + INDEX_W)'(pick);
  assign count_ext  = (CW + COUNT_W)'(count);
  assign age_next   = age_counter + AGE_W'(1);

  vaos_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VOICES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write_voice),
    .waddr (pick),
    .wdata ({age_next, item_id, item_note}),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      held        <= '0;
      count       <= '0;
      age_counter <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
      if (cmd.load && end_clear) begin
        active[end_idx] <= 1'b0;
        count           <= count - CW'(1);
      end
      if (rel_hit) begin
        held[rd_idx] <= 1'b0;
      end
      if (cmd.write_voice) begin
        active[pick] <= 1'b1;
        held[pick]   <= 1'b1;
        age_counter  <= age_next;
        if (!active[pick]) count <= count + CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (cmd.load) begin
      mode_alloc <= is_on;
      item_note  <= in_note;
      item_id    <= in_voice_id;
      addr       <= '0;
      pick       <= free_idx;
      found      <= 1'b0;
      best_age   <= '0;
      r_alloc    <= 1'b0;
      r_stolen   <= 1'b0;
      r_mask     <= '0;
    end
    if (cmd.scan_issue) begin
      addr <= addr + VW'(1);
    end
    if (age_better) begin
      pick     <= rd_idx;
      found    <= 1'b1;
      best_age <= rd_age;
    end
    if (rel_hit && rd_in_mask) begin
      r_mask[rd_ext[INDEX_W-1:0]] <= 1'b1;
    end
    if (cmd.write_voice) begin
      r_alloc  <= 1'b1;
      r_stolen <= active[pick];
    end
    if (cmd.emit) begin
      out_allocated    <= r_alloc;
      out_voice_index  <= r_alloc ? pick_ext[INDEX_W-1:0] : '0;
      out_stolen       <= r_stolen;
      out_release_mask <= r_mask;
      out_active_count <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/voice_allocator_oldest_steal.sv =====
// Polyphonic voice allocator with oldest-voice stealing.
// Requests arrive on the req channel and each gives exactly one transfer on the res
// channel; both use valid/ready and a transfer happens when both are high.
// An envelope-end event, a note-off that is a bend update, a note-on with zero
// velocity or an unknown request goes from idle straight to the done state, which
// loads the result into the output register; a note-on with a free voice passes
// the write state first. A note-off walks the voice table one voice per cycle, as
// does a note-on when every voice is active (oldest non-held voice search), in the
// scan and drain states; a note-on then passes the write state for the voice write.
// The single read port of the voice table RAM sets that walk. One request is in
// flight at a time; req.ready is high only while the block is idle, so a new request
// can follow in the cycle after the result is loaded into the output register.
// Reset clears all voices to inactive and released, the age counter to zero and
// drops res.valid; the table RAM needs no clearing, as only active voices' entries are used.
// When the receiver stalls, the result is held in the output register and the block
// does not return to idle until that register can be reloaded.
// Depends on vaos_pkg, vaos_req_if, vaos_res_if, vaos_ctrl, vaos_dp and vaos_ram.
`default_nettype none

module voice_allocator_oldest_steal import vaos_pkg::*; #(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input logic        clk,
  input logic        rst,
  vaos_req_if.sink   req,
  vaos_res_if.source res
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  vaos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  vaos_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .in_req_type      (req.req_type),
    .in_note          (req.note),
    .in_voice_id      (req.voice_id),
    .in_velocity      (req.velocity),
    .in_bend_update   (req.bend_update),
    .in_ended_voice   (req.ended_voice),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .out_allocated    (res.allocated),
    .out_voice_index  (res.voice_index),
    .out_stolen       (res.stolen),
    .out_release_mask (res.release_mask),
    .out_active_count (res.active_count)
  );

endmodule

`default_nettype wire

// ===== src/vaos_check.sv =====
// Port-level checks for the voice allocator, bound to the top level.
// Depends on vaos_pkg for field widths.
`default_nettype none

module vaos_check import vaos_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_allocated,
  input logic [INDEX_W-1:0] res_voice_index,
  input logic               res_stolen,
  input logic [MASK_W-1:0]  res_release_mask
);

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // A result without an allocation names no voice and no steal.
  a_no_alloc_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_allocated |-> res_voice_index == '0 && !res_stolen)
    else $error("voice index or stolen set without allocation");

  a_alloc_no_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_allocated |-> res_release_mask == '0)
    else $error("note-on result carries a release mask");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_release_mask)
                                && $stable(res_voice_index))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind voice_allocator_oldest_steal vaos_check u_vaos_check (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_allocated    (res.allocated),
  .res_voice_index  (res.voice_index),
  .res_stolen       (res.stolen),
  .res_release_mask (res.release_mask)
);

`default_nettype wire
